// File: src/jtag_tap_master_shifter_macros.svh
// Assertion helpers shared by the RTL files
`ifndef JTAG_TAP_MASTER_SHIFTER_MACROS_SVH
`define JTAG_TAP_MASTER_SHIFTER_MACROS_SVH

// Same-cycle implication, muted while reset is asserted
`define JTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, muted while reset is asserted
`define JTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/jts_pkg.sv
`timescale 1ns / 1ps

package jts_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_IR    = 2'd1;
  localparam logic [1:0] CMD_DR    = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // TMS walks, sent from bit 0 upwards
  localparam logic [5:0] PAT_RESET = 6'h1f;  // five ones into reset, then a zero into idle
  localparam logic [5:0] PAT_IR    = 6'h03;
  localparam logic [5:0] PAT_DR    = 6'h01;
  localparam logic [5:0] PAT_EXIT  = 6'h01;

  localparam int LEN_RESET = 6;
  localparam int LEN_IR    = 4;
  localparam int LEN_DR    = 3;
  localparam int LEN_EXIT  = 2;

  localparam int CHUNK_BITS = 8;

  // One TCK cycle as handed from the sequencer to the output stage
  typedef struct packed {
    logic       tms;
    logic       tdi;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       is_last;
  } jts_cycle_t;

endpackage

// File: src/jts_core.sv
`timescale 1ns / 1ps
`include "jtag_tap_master_shifter_macros.svh"

module jts_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                drive_tdi_i,
  input  logic [3:0]          nbits_i,
  input  logic                last_chunk_i,
  input  logic [7:0]          tdo_bits_i,
  input  logic                step_i,
  output logic                busy_o,
  output jts_pkg::jts_cycle_t cyc_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RST   = 3'd1;
  localparam logic [2:0] ST_NAV   = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_EXIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [5:0] pat_q, pat_d;
  logic       in_scan_q, in_scan_d;
  logic       tdi_level_q, tdi_level_d;
  logic [7:0] tx_q, tx_d;
  logic [7:0] cap_q, cap_d;
  logic [2:0] len_q, len_d;
  logic       drive_q, drive_d;
  logic       last_q, last_d;

  logic [3:0] nb_sat;
  logic [7:0] cap_mask;

  // Clamp the bit count to one..eight and build the capture mask from the top
  always_comb begin
    if (nbits_i == 4'd0) begin
      nb_sat = 4'd1;
    end else if (nbits_i > 4'(jts_pkg::CHUNK_BITS)) begin
      nb_sat = 4'(jts_pkg::CHUNK_BITS);
    end else begin
      nb_sat = nbits_i;
    end
    cap_mask = ~(8'hff >> nb_sat);
  end

  // Present the current TCK cycle
  always_comb begin
    cyc_o = '0;
    case (state_q)
      ST_RST, ST_NAV, ST_EXIT: begin
        cyc_o.tms      = pat_q[0];
        cyc_o.tdi      = tdi_level_q;
        cyc_o.rx_valid = (state_q == ST_EXIT) && (cnt_q == 3'd0);
        cyc_o.rx_byte  = cyc_o.rx_valid ? cap_q : 8'h00;
        cyc_o.is_last  = (state_q != ST_NAV) && (cnt_q == 3'd0);
      end
      ST_SHIFT: begin
        cyc_o.tms      = last_q && (cnt_q == 3'd0);
        cyc_o.tdi      = drive_q ? tx_q[7] : tdi_level_q;
        cyc_o.rx_valid = !last_q && (cnt_q == 3'd0);
        cyc_o.rx_byte  = cyc_o.rx_valid ? cap_q : 8'h00;
        cyc_o.is_last  = !last_q && (cnt_q == 3'd0);
      end
      default: begin
        cyc_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // Sequencer: load on transfer, then advance the shared shifter one TCK a step
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pat_d       = pat_q;
    in_scan_d   = in_scan_q;
    tdi_level_d = tdi_level_q;
    tx_d        = tx_q;
    cap_d       = cap_q;
    len_d       = len_q;
    drive_d     = drive_q;
    last_d      = last_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          tx_d    = tx_byte_i;
          cap_d   = tdo_bits_i & cap_mask;
          len_d   = 3'(nb_sat - 4'd1);
          drive_d = drive_tdi_i;
          last_d  = last_chunk_i;
          case (cmd_i)
            jts_pkg::CMD_RESET: begin
              state_d   = ST_RST;
              pat_d     = jts_pkg::PAT_RESET;
              cnt_d     = 3'(jts_pkg::LEN_RESET - 1);
              in_scan_d = 1'b0;
            end
            jts_pkg::CMD_IR, jts_pkg::CMD_DR: begin
              if (in_scan_q) begin
                state_d = ST_SHIFT;
                cnt_d   = 3'(nb_sat - 4'd1);
              end else if (cmd_i == jts_pkg::CMD_IR) begin
                state_d = ST_NAV;
                pat_d   = jts_pkg::PAT_IR;
                cnt_d   = 3'(jts_pkg::LEN_IR - 1);
              end else begin
                state_d = ST_NAV;
                pat_d   = jts_pkg::PAT_DR;
                cnt_d   = 3'(jts_pkg::LEN_DR - 1);
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RST, ST_EXIT: begin
        if (step_i) begin
          pat_d = pat_q >> 1;
          cnt_d = cnt_q - 3'd1;
          if (cnt_q == 3'd0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_NAV: begin
        if (step_i) begin
          pat_d = pat_q >> 1;
          cnt_d = cnt_q - 3'd1;
          if (cnt_q == 3'd0) begin
            state_d = ST_SHIFT;
            cnt_d   = len_q;
          end
        end
      end
      ST_SHIFT: begin
        if (step_i) begin
          if (drive_q) begin
            tdi_level_d = tx_q[7];
          end
          tx_d  = {tx_q[6:0], 1'b0};
          cnt_d = cnt_q - 3'd1;
          if (cnt_q == 3'd0) begin
            if (last_q) begin
              state_d   = ST_EXIT;
              pat_d     = jts_pkg::PAT_EXIT;
              cnt_d     = 3'(jts_pkg::LEN_EXIT - 1);
              in_scan_d = 1'b0;
            end else begin
              state_d   = ST_IDLE;
              in_scan_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pat_q       <= '0;
      in_scan_q   <= 1'b0;
      tdi_level_q <= 1'b0;
      cap_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pat_q       <= pat_d;
      in_scan_q   <= in_scan_d;
      tdi_level_q <= tdi_level_d;
      cap_q       <= cap_d;
    end
  end

  // Chunk payload
  always_ff @(posedge clk_i) begin
    tx_q    <= tx_d;
    len_q   <= len_d;
    drive_q <= drive_d;
    last_q  <= last_d;
  end

  `JTS_ASSERT_IMP(a_rx_on_last, clk_i, rst_ni, cyc_o.rx_valid, cyc_o.is_last)
  `JTS_ASSERT_IMP(a_nav_from_idle, clk_i, rst_ni, state_q == ST_NAV, !in_scan_q)
  `JTS_ASSERT_NXT(a_chunk_open, clk_i, rst_ni,
                  step_i && state_q == ST_SHIFT && cnt_q == 3'd0 && !last_q,
                  in_scan_q && state_q == ST_IDLE)
  `JTS_ASSERT_NXT(a_exit_done, clk_i, rst_ni,
                  step_i && state_q == ST_EXIT && cnt_q == 3'd0,
                  state_q == ST_IDLE && !in_scan_q)

endmodule

// File: src/jtag_tap_master_shifter.sv
// Output: the sequencer registers an item at transfer, and its first TCK cycle enters the
// output register on the next step. Throughput: one TCK cycle per clock while the output side
// takes them; an item gives the reset walk, or a navigation walk (none inside a scan), the
// clamped bit count and, on the last chunk, the exit walk. The next item is accepted once the
// block is idle, in the cycle after the last of these steps; an ignored command keeps it idle.
// Reset: asynchronous active-low; the TAP is taken as idle, TDI level and capture clear.
`timescale 1ns / 1ps
`include "jtag_tap_master_shifter_macros.svh"

module jtag_tap_master_shifter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // tdata: tx_byte[7:0], drive_tdi[8], nbits[12:9], tdo_bits[20:13], zero[23:21]
  input  logic [23:0] s_tdata_i,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_tuser_i,
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // tdata: tms_out[0], tdi_out[1], rx_byte[9:2], zero[15:10]
  output logic [15:0] m_tdata_o,
  // tuser: rx_valid[0]
  output logic [0:0]  m_tuser_o,
  output logic        m_tlast_o
);

  logic                busy;
  logic                step;
  jts_pkg::jts_cycle_t cyc;
  logic                out_valid_q, out_valid_d;
  jts_pkg::jts_cycle_t out_q;

  assign s_tready_o = !busy;
  assign step       = busy && (!out_valid_q || m_tready_i);

  jts_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (s_tvalid_i && s_tready_o),
    .cmd_i        (s_tuser_i),
    .tx_byte_i    (s_tdata_i[7:0]),
    .drive_tdi_i  (s_tdata_i[8]),
    .nbits_i      (s_tdata_i[12:9]),
    .last_chunk_i (s_tlast_i),
    .tdo_bits_i   (s_tdata_i[20:13]),
    .step_i       (step),
    .busy_o       (busy),
    .cyc_o        (cyc)
  );

  // Output register: fill on a step, drop once the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= cyc;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'b0, out_q.rx_byte, out_q.tdi, out_q.tms};
  assign m_tuser_o  = out_q.rx_valid;
  assign m_tlast_o  = out_q.is_last;

  `JTS_ASSERT_NXT(a_hold_stall, clk_i, rst_ni, out_valid_q && !m_tready_i,
                  out_valid_q && $stable(m_tdata_o))
  `JTS_ASSERT_IMP(a_step_room, clk_i, rst_ni, step, !out_valid_q || m_tready_i)
  `JTS_ASSERT_IMP(a_rx_tlast, clk_i, rst_ni, out_valid_q && out_q.rx_valid, out_q.is_last)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  // One command as offered on the input stream
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] tx;
    logic       drive;
    logic [3:0] nbits;
    logic       last;
    logic [7:0] tdo;
  } tap_cmd_t;

  // Receiver pacing styles
  typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOPPY} rx_mode_e;

  // Predicts the TMS/TDI walk of each command and checks every output transfer against it
  class tap_walk_board;
    jts_pkg::jts_cycle_t want_cycles[$];
    logic       in_scan;
    logic       tdi_level;
    int         n_errors;
    int         n_cmds;
    int         n_resets;
    int         n_ignored;
    int         n_cycles;
    int         n_captures;

    function new();
      in_scan   = 1'b0;
      tdi_level = 1'b0;
    endfunction

    function void push_tck(logic tms);
      jts_pkg::jts_cycle_t c;
      c          = '0;
      c.tms      = tms;
      c.tdi      = tdi_level;
      want_cycles.push_back(c);
    endfunction

    // Walk a TMS pattern from bit 0 upwards with TDI held
    function void walk(logic [5:0] pat, int len);
      for (int i = 0; i < len; i++) push_tck(pat[i]);
    endfunction

    // Mark the closing cycle of a command, with the captured byte where there is one
    function void close_cmd(logic rxv, logic [7:0] rxb);
      jts_pkg::jts_cycle_t c;
      c          = want_cycles.pop_back();
      c.rx_valid = rxv;
      c.rx_byte  = rxb;
      c.is_last  = 1'b1;
      want_cycles.push_back(c);
    endfunction

    function void note_command(tap_cmd_t r);
      int         nb;
      int         pos;
      logic [7:0] capture;
      if (r.cmd == jts_pkg::CMD_NONE) begin
        n_ignored++;
        return;
      end
      n_cmds++;
      if (r.cmd == jts_pkg::CMD_RESET) begin
        n_resets++;
        walk(jts_pkg::PAT_RESET, jts_pkg::LEN_RESET);
        in_scan = 1'b0;
        close_cmd(1'b0, 8'h00);
        return;
      end
      // zero counts as one bit, anything above a byte saturates
      nb = (r.nbits == 0) ? 1 : (r.nbits > jts_pkg::CHUNK_BITS) ? jts_pkg::CHUNK_BITS
                                                                 : int'(r.nbits);
      // navigate from idle on the first chunk of a scan
      if (!in_scan) begin
        if (r.cmd == jts_pkg::CMD_IR) walk(jts_pkg::PAT_IR, jts_pkg::LEN_IR);
        else walk(jts_pkg::PAT_DR, jts_pkg::LEN_DR);
      end
      capture = '0;
      for (int i = 0; i < nb; i++) begin
        pos = 7 - i;
        if (r.drive) tdi_level = r.tx[pos];
        capture[pos] = r.tdo[pos];
        push_tck(r.last && (i == nb - 1));
      end
      if (r.last) begin
        walk(jts_pkg::PAT_EXIT, jts_pkg::LEN_EXIT);
        in_scan = 1'b0;
      end else begin
        in_scan = 1'b1;
      end
      n_captures++;
      close_cmd(1'b1, capture);
    endfunction

    function void compare(string what, int want, int got);
      if (want != got) begin
        n_errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      end
    endfunction

    function void check_cycle(jts_pkg::jts_cycle_t got);
      jts_pkg::jts_cycle_t want;
      if (want_cycles.size() == 0) begin
        n_errors++;
        $display("%0t: TCK cycle with nothing expected, expected none, actual tms=%0b tdi=%0b",
                 $time, got.tms, got.tdi);
        return;
      end
      want = want_cycles.pop_front();
      n_cycles++;
      compare("tms", want.tms, got.tms);
      compare("tdi", want.tdi, got.tdi);
      compare("rx_valid", want.rx_valid, got.rx_valid);
      compare("rx_byte", want.rx_byte, got.rx_byte);
      compare("is_last", want.is_last, got.is_last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i = '0;
  logic [1:0]  s_tuser_i = jts_pkg::CMD_RESET;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [15:0] m_tdata_o;
  logic [0:0]  m_tuser_o;
  logic        m_tlast_o;

  tap_walk_board board;
  int            burst_left = 0;

  jtag_tap_master_shifter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Check every TCK cycle transfer on the output side
  always @(posedge clk_i) begin
    jts_pkg::jts_cycle_t got;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got          = '0;
      got.tms      = m_tdata_o[0];
      got.tdi      = m_tdata_o[1];
      got.rx_byte  = m_tdata_o[9:2];
      got.rx_valid = m_tuser_o[0];
      got.is_last  = m_tlast_o;
      board.check_cycle(got);
    end
  end

  // Receiver back-pressure, switching style after a random span
  initial begin : rx_pacing
    rx_mode_e mode;
    int       span;
    int       hold;
    mode = RX_OPEN;
    span = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        span = $urandom_range(40, 300);
      end
      span--;
      case (mode)
        RX_OPEN: m_tready_i = 1'b1;
        RX_RANDOM: m_tready_i = ($urandom_range(0, 9) < 7);
        default: begin
          if (hold <= 0) begin
            m_tready_i = ~m_tready_i;
            hold = m_tready_i ? $urandom_range(1, 4) : $urandom_range(1, 12);
          end
          hold--;
        end
      endcase
    end
  end

  function automatic tap_cmd_t mk(logic [1:0] cmd, logic [7:0] tx, logic drive,
                                  logic [3:0] nbits, logic last, logic [7:0] tdo);
    tap_cmd_t r;
    r.cmd   = cmd;
    r.tx    = tx;
    r.drive = drive;
    r.nbits = nbits;
    r.last  = last;
    r.tdo   = tdo;
    return r;
  endfunction

  // Offer one command in bursts with random gaps, hold until transfer
  task automatic send_cmd(input tap_cmd_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      s_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_tvalid_i = 1'b1;
    s_tuser_i  = r.cmd;
    s_tlast_i  = r.last;
    s_tdata_i  = {3'b000, r.tdo, r.nbits, r.drive, r.tx};
    do @(posedge clk_i); while (!s_tready_o);
    board.note_command(r);
  endtask

  // Hold off the sender until every predicted cycle has come out
  task automatic drain();
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    while (board.want_cycles.size() != 0) @(posedge clk_i);
  endtask

  // A well-formed scan of one kind, split into byte chunks
  task automatic random_scan();
    logic [1:0] kind;
    int         chunks;
    tap_cmd_t   r;
    kind   = $urandom_range(0, 1) ? jts_pkg::CMD_IR : jts_pkg::CMD_DR;
    chunks = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : $urandom_range(1, 2);
    for (int c = 0; c < chunks; c++) begin
      r.cmd   = kind;
      r.tx    = 8'($urandom);
      r.drive = ($urandom_range(0, 4) != 0);
      r.nbits = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
      r.last  = (c == chunks - 1);
      r.tdo   = 8'($urandom);
      send_cmd(r);
    end
  endtask

  initial begin : stimulus
    int  pick;
    bit  mid_drained;
    board = new();
    mid_drained = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every command, odd bit counts, held TDI, aborts
    send_cmd(mk(jts_pkg::CMD_RESET, 8'h00, 1'b0, 4'd0, 1'b0, 8'h00));
    send_cmd(mk(jts_pkg::CMD_IR, 8'hff, 1'b1, 4'd8, 1'b1, 8'h00));
    send_cmd(mk(jts_pkg::CMD_DR, 8'h00, 1'b1, 4'd8, 1'b1, 8'hff));
    send_cmd(mk(jts_pkg::CMD_DR, 8'h80, 1'b1, 4'd1, 1'b1, 8'h80));
    send_cmd(mk(jts_pkg::CMD_DR, 8'hff, 1'b1, 4'd0, 1'b1, 8'hff));
    send_cmd(mk(jts_pkg::CMD_IR, 8'ha5, 1'b1, 4'd15, 1'b1, 8'h5a));
    send_cmd(mk(jts_pkg::CMD_DR, 8'h00, 1'b0, 4'd9, 1'b1, 8'h3c));
    send_cmd(mk(jts_pkg::CMD_NONE, 8'hff, 1'b1, 4'd15, 1'b1, 8'hff));
    // multi-chunk instruction scan closed by a data chunk
    send_cmd(mk(jts_pkg::CMD_IR, 8'h96, 1'b1, 4'd8, 1'b0, 8'h69));
    send_cmd(mk(jts_pkg::CMD_IR, 8'h38, 1'b1, 4'd5, 1'b0, 8'hc7));
    send_cmd(mk(jts_pkg::CMD_DR, 8'he0, 1'b1, 4'd3, 1'b1, 8'ha0));
    // reset from inside a scan, then a fresh scan
    send_cmd(mk(jts_pkg::CMD_DR, 8'h5a, 1'b1, 4'd4, 1'b0, 8'hf0));
    send_cmd(mk(jts_pkg::CMD_RESET, 8'hff, 1'b1, 4'd8, 1'b1, 8'hff));
    send_cmd(mk(jts_pkg::CMD_DR, 8'h3c, 1'b1, 4'd8, 1'b1, 8'h0f));
    // ignored command in the middle of a scan with TDI held
    send_cmd(mk(jts_pkg::CMD_DR, 8'h00, 1'b0, 4'd8, 1'b0, 8'h81));
    send_cmd(mk(jts_pkg::CMD_NONE, 8'h00, 1'b0, 4'd0, 1'b0, 8'h00));
    send_cmd(mk(jts_pkg::CMD_DR, 8'hc0, 1'b1, 4'd2, 1'b1, 8'h40));
    send_cmd(mk(jts_pkg::CMD_IR, 8'h0f, 1'b1, 4'd4, 1'b1, 8'hf0));
    drain();

    // random: mostly proper scans, some resets and loose commands
    while (board.n_cmds + board.n_ignored < 450) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_scan();
      end else if (pick < 82) begin
        send_cmd(mk(jts_pkg::CMD_RESET, 8'($urandom), 1'($urandom), 4'($urandom),
                    1'($urandom), 8'($urandom)));
      end else begin
        send_cmd(mk(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 4'($urandom),
                    1'($urandom), 8'($urandom)));
      end
      if (!mid_drained && board.n_cmds > 250) begin
        drain();
        mid_drained = 1'b1;
      end
    end

    drain();
    repeat (16) @(posedge clk_i);

    $display("Covered %0d commands (%0d resets) plus %0d ignored, over %0d TCK cycles",
             board.n_cmds, board.n_resets, board.n_ignored, board.n_cycles);
    $display("with %0d captured chunks and %0d cycles still outstanding",
             board.n_captures, board.want_cycles.size());
    if (board.n_errors == 0 && board.want_cycles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
